/* hdl/jtep_pkg.sv */
// Shared widths, event codes and structs of the JSON token event parser.
package jtep_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW = $clog2(STACK_DEPTH + 1);

  localparam int CHAR_W = 21;
  localparam int KIND_W = 5;
  localparam int LINE_W = 16;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_NONE      = 5'd0;
  localparam logic [KIND_W-1:0] EV_OBJ_START = 5'd1;
  localparam logic [KIND_W-1:0] EV_OBJ_END   = 5'd2;
  localparam logic [KIND_W-1:0] EV_ARR_START = 5'd3;
  localparam logic [KIND_W-1:0] EV_ARR_END   = 5'd4;
  localparam logic [KIND_W-1:0] EV_NAME_CHAR = 5'd5;
  localparam logic [KIND_W-1:0] EV_NAME_END  = 5'd6;
  localparam logic [KIND_W-1:0] EV_STR_CHAR  = 5'd7;
  localparam logic [KIND_W-1:0] EV_STR_END   = 5'd8;
  localparam logic [KIND_W-1:0] EV_NULL      = 5'd9;
  localparam logic [KIND_W-1:0] EV_TRUE      = 5'd10;
  localparam logic [KIND_W-1:0] EV_FALSE     = 5'd11;
  localparam logic [KIND_W-1:0] EV_NUM_CHAR  = 5'd12;
  localparam logic [KIND_W-1:0] EV_INT_END   = 5'd13;
  localparam logic [KIND_W-1:0] EV_FLOAT_END = 5'd14;
  localparam logic [KIND_W-1:0] EV_DOC_END   = 5'd15;
  localparam logic [KIND_W-1:0] EV_ERROR     = 5'd16;

  // One result word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [LINE_W-1:0] line;
    logic              last;
  } ev_t;

  // Return-stack request from the parse step
  typedef struct packed {
    logic       push;
    logic [1:0] code;
    logic [1:0] npop;
  } stk_op_t;

  // Return-stack view: fill count and the two top entries
  typedef struct packed {
    logic [STK_CW-1:0] cnt;
    logic [1:0]        top0;
    logic [1:0]        top1;
  } stk_st_t;

endpackage

/* hdl/jtep_stack.sv */
// Return stack: entry memory with a registered cache of the two top entries.
module jtep_stack (
  input  logic              clk,
  input  logic              rst_n,
  input  jtep_pkg::stk_op_t op,
  output jtep_pkg::stk_st_t st
);
  import jtep_pkg::*;

  logic [1:0]        mem [STACK_DEPTH];
  logic [STK_CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]        top0_r, top1_r;
  logic [STK_AW-1:0] wa, ra0, ra1;

  assign cnt_nxt = cnt_r + STK_CW'(op.push) - STK_CW'(op.npop);
  assign wa      = cnt_r[STK_AW-1:0];
  assign ra0     = STK_AW'(cnt_nxt - STK_CW'(1));
  assign ra1     = STK_AW'(cnt_nxt - STK_CW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wa] <= op.code;
    end
  end

  // Refetch the top two for the next count; a push lands in top0 directly.
  always_ff @(posedge clk) begin
    top0_r <= op.push ? op.code : mem[ra0];
    top1_r <= mem[ra1];
  end

  assign st.cnt  = cnt_r;
  assign st.top0 = top0_r;
  assign st.top1 = top1_r;

endmodule

/* hdl/jtep_step.sv */
// Parse step: mode, literal progress, line count and error flag with next-state logic.
module jtep_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [jtep_pkg::CHAR_W-1:0]   c,
  input  logic                          eof,
  input  jtep_pkg::stk_st_t             stk,
  output jtep_pkg::stk_op_t             op,
  output logic [1:0]                    ev_n,
  output jtep_pkg::ev_t [1:0]           evs
);
  import jtep_pkg::*;

  localparam logic [3:0] M_DOC        = 4'd0;
  localparam logic [3:0] M_DOC_END    = 4'd1;
  localparam logic [3:0] M_OBJ        = 4'd2;
  localparam logic [3:0] M_NAME       = 4'd3;
  localparam logic [3:0] M_NAME_END   = 4'd4;
  localparam logic [3:0] M_ASSIGN     = 4'd5;
  localparam logic [3:0] M_MEMBER_END = 4'd6;
  localparam logic [3:0] M_ARR        = 4'd7;
  localparam logic [3:0] M_ARR_END    = 4'd8;
  localparam logic [3:0] M_STR        = 4'd9;
  localparam logic [3:0] M_LIT        = 4'd10;
  localparam logic [3:0] M_NUM        = 4'd11;
  localparam logic [3:0] M_FRAC       = 4'd12;

  localparam logic [1:0] RC_DOC    = 2'd0;
  localparam logic [1:0] RC_MEMBER = 2'd1;
  localparam logic [1:0] RC_ARR    = 2'd2;

  localparam logic [4:0] LIT_NONE        = 5'd0;
  localparam logic [4:0] LIT_NULL_START  = 5'd1;
  localparam logic [4:0] LIT_TRUE_START  = 5'd5;
  localparam logic [4:0] LIT_FALSE_START = 5'd9;
  localparam logic [4:0] LIT_BAD         = 5'd31;

  localparam logic [CHAR_W-1:0] CH_TAB    = 21'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 21'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'h22;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 21'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 21'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 21'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 21'h2E;
  localparam logic [CHAR_W-1:0] CH_COLON  = 21'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 21'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 21'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 21'h7D;
  localparam logic [CHAR_W-1:0] CH_LOW_E  = 21'h65;
  localparam logic [CHAR_W-1:0] CH_UP_E   = 21'h45;
  localparam logic [CHAR_W-1:0] CH_LOW_F  = 21'h66;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 21'h6E;
  localparam logic [CHAR_W-1:0] CH_LOW_T  = 21'h74;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);

  typedef struct packed {
    logic [3:0]             mode;
    logic [4:0]             lit;
    logic                   err;
    logic [STK_CW-1:0]      cnt;
    logic [1:0]             npop;
    logic                   push;
    logic [1:0]             code;
    logic [1:0]             n;
    logic [1:0][KIND_W-1:0] kind;
    logic [1:0][CHAR_W-1:0] ch;
  } scr_t;

  logic [3:0]        mode_r, mode_nxt;
  logic [4:0]        lit_r, lit_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              err_r, err_nxt;
  scr_t              s;

  function automatic logic is_space(logic [CHAR_W-1:0] ch, logic e);
    return !e && (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF);
  endfunction

  function automatic logic is_digit(logic [CHAR_W-1:0] ch);
    return ch >= CHAR_W'(8'h30) && ch <= CHAR_W'(8'h39);
  endfunction

  function automatic logic is_alpha(logic [CHAR_W-1:0] ch);
    return (ch >= CHAR_W'(8'h61) && ch <= CHAR_W'(8'h7A)) ||
           (ch >= CHAR_W'(8'h41) && ch <= CHAR_W'(8'h5A));
  endfunction

  function automatic logic is_numch(logic [CHAR_W-1:0] ch);
    return is_digit(ch) || ch == CH_MINUS || ch == CH_PLUS ||
           ch == CH_LOW_E || ch == CH_UP_E;
  endfunction

  function automatic logic [3:0] ret_mode(logic [1:0] code);
    logic [3:0] m;
    case (code)
      RC_MEMBER: m = M_MEMBER_END;
      RC_ARR:    m = M_ARR_END;
      default:   m = M_DOC_END;
    endcase
    return m;
  endfunction

  // Next letter expected at a given literal progress; zero past the end.
  function automatic logic [7:0] lit_next(logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd1:    r = 8'h75;
      5'd2:    r = 8'h6C;
      5'd3:    r = 8'h6C;
      5'd5:    r = 8'h72;
      5'd6:    r = 8'h75;
      5'd7:    r = 8'h65;
      5'd9:    r = 8'h61;
      5'd10:   r = 8'h6C;
      5'd11:   r = 8'h73;
      5'd12:   r = 8'h65;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Event for a fully spelled literal, none otherwise.
  function automatic logic [KIND_W-1:0] lit_end_kind(logic [4:0] p);
    logic [KIND_W-1:0] k;
    case (p)
      5'd4:    k = EV_NULL;
      5'd8:    k = EV_TRUE;
      5'd13:   k = EV_FALSE;
      default: k = EV_NONE;
    endcase
    return k;
  endfunction

  function automatic scr_t f_emit(scr_t x, logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch);
    if (!x.err && x.n < 2'd2) begin
      x.kind[x.n[0]] = k;
      x.ch[x.n[0]]   = ch;
      x.n            = x.n + 2'd1;
    end
    return x;
  endfunction

  function automatic scr_t f_fail(scr_t x);
    x     = f_emit(x, EV_ERROR, '0);
    x.err = 1'b1;
    return x;
  endfunction

  function automatic scr_t f_pop(scr_t x, logic [1:0] t0, logic [1:0] t1);
    if (x.cnt == '0) begin
      x = f_fail(x);
    end else begin
      x.cnt  = x.cnt - STK_CW'(1);
      x.mode = ret_mode((x.npop == 2'd0) ? t0 : t1);
      x.npop = x.npop + 2'd1;
    end
    return x;
  endfunction

  function automatic scr_t f_push(scr_t x, logic [1:0] code);
    if (x.cnt >= STK_CW'(STACK_DEPTH)) begin
      x = f_fail(x);
    end else begin
      x.push = 1'b1;
      x.code = code;
      x.cnt  = x.cnt + STK_CW'(1);
    end
    return x;
  endfunction

  function automatic scr_t f_element(scr_t x, logic [CHAR_W-1:0] ch, logic e);
    if (e) begin
      x = f_fail(x);
    end else if (ch == CH_LBRACE) begin
      x      = f_emit(x, EV_OBJ_START, '0);
      x.mode = M_OBJ;
    end else if (ch == CH_LBRACK) begin
      x      = f_emit(x, EV_ARR_START, '0);
      x.mode = M_ARR;
    end else if (ch == CH_QUOTE) begin
      x.mode = M_STR;
    end else if (ch == CH_LOW_N) begin
      x.mode = M_LIT;
      x.lit  = LIT_NULL_START;
    end else if (ch == CH_LOW_T) begin
      x.mode = M_LIT;
      x.lit  = LIT_TRUE_START;
    end else if (ch == CH_LOW_F) begin
      x.mode = M_LIT;
      x.lit  = LIT_FALSE_START;
    end else if (is_digit(ch) || ch == CH_MINUS) begin
      x.mode = M_NUM;
      x      = f_emit(x, EV_NUM_CHAR, ch);
    end else begin
      x = f_fail(x);
    end
    return x;
  endfunction

  function automatic scr_t f_close(scr_t x, logic [CHAR_W-1:0] ch, logic e,
                                   logic [CHAR_W-1:0] closer, logic [KIND_W-1:0] k,
                                   logic [3:0] again, logic [1:0] t0, logic [1:0] t1);
    if (is_space(ch, e)) begin
      x = x;
    end else if (!e && ch == closer) begin
      x = f_pop(x, t0, t1);
      if (!x.err) begin
        x = f_emit(x, k, '0);
      end
    end else if (!e && ch == CH_COMMA) begin
      x.mode = again;
    end else begin
      x = f_fail(x);
    end
    return x;
  endfunction

  // Handle an input in a return mode, including the input that ends a literal or number.
  function automatic scr_t f_simple(scr_t x, logic [CHAR_W-1:0] ch, logic e,
                                    logic [1:0] t0, logic [1:0] t1);
    unique case (x.mode)
      M_MEMBER_END: x = f_close(x, ch, e, CH_RBRACE, EV_OBJ_END, M_OBJ, t0, t1);
      M_ARR_END:    x = f_close(x, ch, e, CH_RBRACK, EV_ARR_END, M_ARR, t0, t1);
      default: begin
        if (e) begin
          x = f_emit(x, EV_DOC_END, '0);
        end else if (!is_space(ch, e)) begin
          x = f_fail(x);
        end
      end
    endcase
    return x;
  endfunction

  function automatic scr_t f_dispatch(scr_t x, logic [CHAR_W-1:0] ch, logic e,
                                      logic [1:0] t0, logic [1:0] t1);
    logic              sp;
    logic [7:0]        nc;
    logic [KIND_W-1:0] lk;
    sp = is_space(ch, e);
    nc = lit_next(x.lit);
    lk = lit_end_kind(x.lit);
    unique case (x.mode) inside
      M_DOC: begin
        if (e) begin
          x = f_emit(x, EV_DOC_END, '0);
        end else if (!sp) begin
          x = f_push(x, RC_DOC);
          if (!x.err) x = f_element(x, ch, e);
        end
      end
      M_OBJ: begin
        if (e) begin
          x = f_fail(x);
        end else if (sp) begin
          x = x;
        end else if (ch == CH_RBRACE) begin
          x = f_pop(x, t0, t1);
          if (!x.err) x = f_emit(x, EV_OBJ_END, '0);
        end else if (ch == CH_QUOTE) begin
          x.mode = M_NAME;
        end else begin
          x = f_fail(x);
        end
      end
      M_NAME: begin
        if (e) begin
          x = f_fail(x);
        end else if (ch == CH_QUOTE) begin
          x      = f_emit(x, EV_NAME_END, '0);
          x.mode = M_NAME_END;
        end else begin
          x = f_emit(x, EV_NAME_CHAR, ch);
        end
      end
      M_NAME_END: begin
        if (sp) begin
          x = x;
        end else if (!e && ch == CH_COLON) begin
          x.mode = M_ASSIGN;
        end else begin
          x = f_fail(x);
        end
      end
      M_ASSIGN: begin
        if (!sp) begin
          x = f_push(x, RC_MEMBER);
          if (!x.err) x = f_element(x, ch, e);
        end
      end
      M_ARR: begin
        if (e) begin
          x = f_fail(x);
        end else if (sp) begin
          x = x;
        end else if (ch == CH_RBRACK) begin
          x = f_pop(x, t0, t1);
          if (!x.err) x = f_emit(x, EV_ARR_END, '0);
        end else begin
          x = f_push(x, RC_ARR);
          if (!x.err) x = f_element(x, ch, e);
        end
      end
      M_STR: begin
        if (e) begin
          x = f_fail(x);
        end else if (ch == CH_QUOTE) begin
          x = f_pop(x, t0, t1);
          if (!x.err) x = f_emit(x, EV_STR_END, '0);
        end else begin
          x = f_emit(x, EV_STR_CHAR, ch);
        end
      end
      M_LIT: begin
        if (!e && is_alpha(ch)) begin
          // advance on the expected letter, poison on anything else
          if (nc != 8'h00 && ch == CHAR_W'(nc)) begin
            x.lit = x.lit + 5'd1;
          end else begin
            x.lit = LIT_BAD;
          end
        end else begin
          x.lit = LIT_NONE;
          if (lk == EV_NONE) begin
            x = f_fail(x);
          end else begin
            x = f_emit(x, lk, '0);
            x = f_pop(x, t0, t1);
            if (!x.err) x = f_simple(x, ch, e, t0, t1);
          end
        end
      end
      M_NUM, M_FRAC: begin
        if (!e && is_numch(ch)) begin
          x = f_emit(x, EV_NUM_CHAR, ch);
        end else if (!e && ch == CH_DOT && x.mode == M_NUM) begin
          x      = f_emit(x, EV_NUM_CHAR, ch);
          x.mode = M_FRAC;
        end else begin
          x = f_emit(x, (x.mode == M_NUM) ? EV_INT_END : EV_FLOAT_END, '0);
          x = f_pop(x, t0, t1);
          if (!x.err) x = f_simple(x, ch, e, t0, t1);
        end
      end
      default: x = f_simple(x, ch, e, t0, t1);
    endcase
    return x;
  endfunction

  always_comb begin
    s      = '0;
    s.mode = mode_r;
    s.lit  = lit_r;
    s.err  = err_r;
    s.cnt  = stk.cnt;
    line_nxt = line_r;
    if (err_r) begin
      // sticky: one error word per input, line frozen
      s.n       = 2'd1;
      s.kind[0] = EV_ERROR;
    end else begin
      s = f_dispatch(s, c, eof, stk.top0, stk.top1);
      if (!s.err && !eof && c == CH_LF && line_r != LINE_MAX) begin
        line_nxt = line_r + LINE_ONE;
      end
    end
    mode_nxt = s.mode;
    lit_nxt  = s.lit;
    err_nxt  = s.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_DOC;
      lit_r  <= LIT_NONE;
      line_r <= LINE_ONE;
      err_r  <= 1'b0;
    end else if (go) begin
      mode_r <= mode_nxt;
      lit_r  <= lit_nxt;
      line_r <= line_nxt;
      err_r  <= err_nxt;
    end
  end

  assign op.push = go & s.push;
  assign op.code = s.code;
  assign op.npop = go ? s.npop : 2'd0;
  assign ev_n    = go ? s.n : 2'd0;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      evs[i].kind = s.kind[i];
      evs[i].ch   = s.ch[i];
      evs[i].line = line_nxt;
      evs[i].last = (s.n == 2'(i + 1));
    end
  end

endmodule

/* hdl/jtep_outq.sv */
// Result queue: takes up to two words a cycle, hands out one word a cycle while out_stall is low.
module jtep_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [1:0]                wr_n,
  input  jtep_pkg::ev_t [1:0]       wr_ev,
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [jtep_pkg::KIND_W-1:0] out_event_kind,
  output logic [jtep_pkg::CHAR_W-1:0] out_event_char,
  output logic [jtep_pkg::LINE_W-1:0] out_line_number,
  output logic                      out_last
);
  import jtep_pkg::*;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  ev_t              q [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             rd;
  ev_t              head;

  assign rd      = (cnt_r != '0) && !out_stall;
  assign cnt_nxt = cnt_r + OQ_CW'(wr_n) - OQ_CW'(rd);
  assign wp_nxt  = wp_r + OQ_AW'(wr_n);
  assign rp_nxt  = rp_r + OQ_AW'(rd);
  // keep space for the two words one item may cause
  assign room    = cnt_r <= OQ_CW'(OQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      q[wp_r] <= wr_ev[0];
    end
    if (wr_n == 2'd2) begin
      q[wp_r + OQ_AW'(1)] <= wr_ev[1];
    end
  end

  assign head            = q[rp_r];
  assign out_valid       = cnt_r != '0;
  assign out_event_kind  = head.kind;
  assign out_event_char  = head.ch;
  assign out_line_number = head.line;
  assign out_last        = head.last;

endmodule

/* hdl/json_token_event_parser_core.sv */
// Top level of the JSON token event parser: input register, parse step, return stack, result queue.
//
// Streaming JSON parser taking one code point (or an end-of-input mark) per input word and
// producing zero, one or two event words per input on the out channel, in order, each with
// the line number current after that input and last set on the final word of the input.
// An input word is registered, then parsed against the 32-entry return stack, whose two top
// entries are held in registers so that a closing token can pop twice for one input; the
// events enter a four-word queue. An input passes the input register and the queue on its way out.
// Sustained rate is one input per cycle while inputs cause at most one word each and the out
// channel is not stalled; the out channel drains one word per cycle, so inputs causing two words
// hold back the input. After a syntax error every input yields a single error word.
module json_token_event_parser_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [jtep_pkg::CHAR_W-1:0] in_character,
  input  logic                        in_end_of_input,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [jtep_pkg::KIND_W-1:0] out_event_kind,
  output logic [jtep_pkg::CHAR_W-1:0] out_event_char,
  output logic [jtep_pkg::LINE_W-1:0] out_line_number,
  output logic                        out_last
);
  import jtep_pkg::*;

  logic              in_vld_r;
  logic [CHAR_W-1:0] ch_r;
  logic              eof_r;
  logic              room;
  logic              go;
  stk_op_t           op;
  stk_st_t           st;
  logic [1:0]        ev_n;
  ev_t [1:0]         evs;

  assign go       = in_vld_r & room;
  assign in_stall = in_vld_r & ~room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_r  <= in_character;
      eof_r <= in_end_of_input;
    end
  end

  jtep_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .st    (st)
  );

  jtep_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .c     (ch_r),
    .eof   (eof_r),
    .stk   (st),
    .op    (op),
    .ev_n  (ev_n),
    .evs   (evs)
  );

  jtep_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_n            (ev_n),
    .wr_ev           (evs),
    .room            (room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_event_char  (out_event_char),
    .out_line_number (out_line_number),
    .out_last        (out_last)
  );

endmodule
